FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file pac_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define PAC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/pac_pkg.sv
package pac_pkg;

    // Block dimensions
    localparam int CAL_POINTS = 6;
    localparam int SAMPLES    = 64;
    localparam int SMP_W      = 10;
    localparam int VAL_W      = 8;
    localparam int SUM_W      = 16;
    localparam int SNAP_W     = 10;
    localparam int NPT_W      = 3;
    localparam int CNT_W      = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    // Calibration tables
    localparam int RAW_TBL_W  = SMP_W * CAL_POINTS;
    localparam int VAL_TBL_W  = VAL_W * CAL_POINTS;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (RAW_TBL_W > VAL_TBL_W) ? RAW_TBL_W : VAL_TBL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_TABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_TABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_USED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZS_ENTER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZS_EXIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SNAP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SNAP    = 3'd6;

    localparam logic [NPT_W-1:0] PTS_RESET = 3'd2;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W  = ((SMP_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((SMP_W + VAL_W + 7) / 8) * 8;

    // Interpolation divider
    localparam int DEN_W      = SMP_W;
    localparam int MAG_W      = SMP_W + VAL_W;
    localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

    // Mean queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    typedef struct packed {
        logic [RAW_TBL_W-1:0] raw_tbl;
        logic [VAL_TBL_W-1:0] val_tbl;
        logic [NPT_W-1:0]     pts_used;
        logic [SNAP_W-1:0]    zs_enter;
        logic [SNAP_W-1:0]    zs_exit;
        logic [SNAP_W-1:0]    low_snap;
        logic [SNAP_W-1:0]    high_snap;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CLASS,
        B_MUL,
        B_START,
        B_DIV,
        B_FIX,
        B_EMIT
    } t_back_state;

endpackage

FILE: rtl/pac_front.sv
module pac_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [pac_pkg::SMP_W-1:0] i_sample,
    input  pac_pkg::t_q_stat          i_q_stat,
    output logic                      o_push,
    output logic [pac_pkg::SMP_W-1:0] o_mean
);
    import pac_pkg::*;

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] n_sum;
    logic             last;
    logic             accept;

    // Close a block on its final sample; stall only if the queue cannot take the mean
    assign last    = (r_cnt == CNT_W'(SAMPLES - 1));
    assign o_ready = !(last && i_q_stat.full);
    assign accept  = i_valid && o_ready;
    assign n_sum   = r_sum + SUM_W'(i_sample);
    assign o_push  = accept && last;
    assign o_mean  = SMP_W'(n_sum / SAMPLES);

    // Accumulate samples, clear at the end of each block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            if (last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/pac_queue.sv
module pac_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [pac_pkg::SMP_W-1:0] i_data,
    input  logic                      i_pop,
    output logic [pac_pkg::SMP_W-1:0] o_data,
    output pac_pkg::t_q_stat          o_stat
);
    import pac_pkg::*;

    logic [SMP_W-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    // Store pushed means
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/pac_div.sv
module pac_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pac_pkg::MAG_W-1:0] i_num,
    input  logic [pac_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [pac_pkg::MAG_W-1:0] o_quot
);
    import pac_pkg::*;

    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [MAG_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DEN_W:0]       shifted;
    logic                 ge;
    logic [DEN_W-1:0]     n_rem;

    // One restoring step: bring down the next numerator bit
    always_comb begin
        shifted = {r_rem, r_quo[MAG_W-1]};
        ge      = (shifted >= {1'b0, r_den});
        if (ge) begin
            n_rem = DEN_W'(shifted - {1'b0, r_den});
        end else begin
            n_rem = shifted[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    // Iterate one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[MAG_W-2:0], ge};
        end
    end

endmodule

FILE: rtl/pac_back.sv
module pac_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pac_pkg::t_cfg             i_cfg,
    input  pac_pkg::t_q_stat          i_q_stat,
    input  logic [pac_pkg::SMP_W-1:0] i_q_data,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [pac_pkg::SMP_W-1:0] o_mean,
    output logic [pac_pkg::VAL_W-1:0] o_cal,
    output logic                      o_zero
);
    import pac_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [SMP_W-1:0] r_mean;
    logic [VAL_W-1:0] r_cal;
    logic             r_was_zero;
    logic [SMP_W-1:0] r_dx;
    logic [DEN_W-1:0] r_span;
    logic [VAL_W-1:0] r_v0;
    logic [VAL_W-1:0] r_dv_mag;
    logic             r_neg;
    logic [MAG_W-1:0] r_mag;

    logic             r_out_valid;
    logic [SMP_W-1:0] r_out_mean;
    logic [VAL_W-1:0] r_out_cal;
    logic             r_out_zero;

    logic             div_start;
    logic             div_done;
    logic [MAG_W-1:0] div_quot;
    logic             emit_ok;

    // Classification signals
    logic [SMP_W-1:0]  raw_pt [CAL_POINTS];
    logic [VAL_W-1:0]  val_pt [CAL_POINTS];
    logic [NPT_W-1:0]  n_use;
    logic [SNAP_W-1:0] snap;
    logic [SMP_W-1:0]  pt_gap;
    logic              zero_hit;
    logic [SMP_W-1:0]  last_raw;
    logic [VAL_W-1:0]  last_val;
    logic              low_hit;
    logic              high_hit;
    logic              seg_found;
    logic [SMP_W-1:0]  seg_lo;
    logic [SMP_W-1:0]  seg_hi;
    logic [VAL_W-1:0]  seg_v0;
    logic [VAL_W-1:0]  seg_v1;
    logic [VAL_W:0]    dv;
    logic [VAL_W:0]    dv_abs;
    logic [VAL_W:0]    q_signed;
    logic [VAL_W:0]    fix_sum;

    // Unpack the tables and clamp the point count
    always_comb begin
        for (int i = 0; i < CAL_POINTS; i++) begin
            raw_pt[i] = i_cfg.raw_tbl[SMP_W*i +: SMP_W];
            val_pt[i] = i_cfg.val_tbl[VAL_W*i +: VAL_W];
        end
        if (i_cfg.pts_used < NPT_W'(2)) begin
            n_use = NPT_W'(2);
        end else if (i_cfg.pts_used > NPT_W'(CAL_POINTS)) begin
            n_use = NPT_W'(CAL_POINTS);
        end else begin
            n_use = i_cfg.pts_used;
        end
    end

    // Zero snap, end snaps and segment search, all points compared side by side
    always_comb begin
        snap     = r_was_zero ? i_cfg.zs_exit : i_cfg.zs_enter;
        zero_hit = 1'b0;
        last_raw = raw_pt[0];
        last_val = val_pt[0];
        pt_gap   = '0;
        for (int i = 0; i < CAL_POINTS; i++) begin
            pt_gap = (r_mean >= raw_pt[i]) ? r_mean - raw_pt[i] : raw_pt[i] - r_mean;
            if ((NPT_W'(i) < n_use) && (val_pt[i] == '0) && (snap != '0)
                    && (pt_gap <= snap)) begin
                zero_hit = 1'b1;
            end
            if (NPT_W'(i) == n_use - NPT_W'(1)) begin
                last_raw = raw_pt[i];
                last_val = val_pt[i];
            end
        end
        low_hit  = ({1'b0, r_mean} <= ({1'b0, raw_pt[0]} + {1'b0, i_cfg.low_snap}));
        high_hit = (({1'b0, r_mean} + {1'b0, i_cfg.high_snap}) >= {1'b0, last_raw});

        // Scan downwards so that the first enclosing segment wins
        seg_found = 1'b0;
        seg_lo    = raw_pt[0];
        seg_hi    = raw_pt[1];
        seg_v0    = val_pt[0];
        seg_v1    = val_pt[1];
        for (int i = CAL_POINTS - 2; i >= 0; i--) begin
            if ((NPT_W'(i + 1) < n_use) && (r_mean >= raw_pt[i])
                    && (r_mean <= raw_pt[i+1])) begin
                seg_found = 1'b1;
                seg_lo    = raw_pt[i];
                seg_hi    = raw_pt[i+1];
                seg_v0    = val_pt[i];
                seg_v1    = val_pt[i+1];
            end
        end
        dv     = {seg_v1[VAL_W-1], seg_v1} - {seg_v0[VAL_W-1], seg_v0};
        dv_abs = dv[VAL_W] ? -dv : dv;
    end

    // Apply sign to the quotient and add the segment start value
    always_comb begin
        q_signed = r_neg ? -{1'b0, div_quot[VAL_W-1:0]} : {1'b0, div_quot[VAL_W-1:0]};
        fix_sum  = {r_v0[VAL_W-1], r_v0} + q_signed;
    end

    assign emit_ok = !r_out_valid || i_ready;

    // Sequencer next state and strobes
    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = B_CLASS;
                end
            end
            B_CLASS: begin
                if (zero_hit || low_hit || high_hit || !seg_found || (seg_hi == seg_lo)) begin
                    n_state = B_EMIT;
                end else begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_state = B_START;
            end
            B_START: begin
                div_start = 1'b1;
                n_state   = B_DIV;
            end
            B_DIV: begin
                if (div_done) begin
                    n_state = B_FIX;
                end
            end
            B_FIX: begin
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (emit_ok) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers for one mean
    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && o_pop) begin
            r_mean <= i_q_data;
        end
        if (r_state == B_CLASS) begin
            priority if (zero_hit) begin
                r_cal <= '0;
            end else if (low_hit) begin
                r_cal <= val_pt[0];
            end else if (high_hit) begin
                r_cal <= last_val;
            end else if (!seg_found) begin
                r_cal <= '0;
            end else begin
                r_cal <= seg_v0;
            end
            r_dx     <= r_mean - seg_lo;
            r_span   <= seg_hi - seg_lo;
            r_v0     <= seg_v0;
            r_neg    <= dv[VAL_W];
            r_dv_mag <= dv_abs[VAL_W-1:0];
        end
        if (r_state == B_MUL) begin
            r_mag <= MAG_W'(r_dx) * MAG_W'(r_dv_mag);
        end
        if (r_state == B_FIX) begin
            r_cal <= fix_sum[VAL_W-1:0];
        end
    end

    // Output register and zero history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_was_zero  <= 1'b0;
        end else if (r_state == B_EMIT && emit_ok) begin
            r_out_valid <= 1'b1;
            r_was_zero  <= (r_cal == '0);
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_EMIT && emit_ok) begin
            r_out_mean <= r_mean;
            r_out_cal  <= r_cal;
            r_out_zero <= (r_cal == '0);
        end
    end

    pac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_mag),
        .i_den   (r_span),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_valid = r_out_valid;
    assign o_mean  = r_out_mean;
    assign o_cal   = r_out_cal;
    assign o_zero  = r_out_zero;

endmodule

FILE: rtl/pot_average_calibrate_snap.sv
// Potentiometer averaging and calibration. Samples are taken one per clock; s_axis_tready
// drops only when the 64th sample of a block arrives while both slots of the two-entry mean
// queue are full. Each block of 64 samples yields one result: the truncated mean and a value
// mapped through the calibration table (zero snap, end snaps, then linear interpolation).
// The calibration back end runs fetch, classify and output load for a snapped, out-of-table
// or zero-width result, and fetch, classify, multiply, start, the bit-serial divider (18
// quotient bits, one per cycle, then a completion flag), sign fix and output load for an
// interpolated one. Results leave through an output register, so the back end keeps working
// while a result waits. Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata;
// the user must write it only while the block is idle, which the block itself does not enforce.
module pot_average_calibrate_snap (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: sample[9:0], zero padding above
    input  logic [pac_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: mean_raw[9:0], calibrated_value[17:10], zero padding above
    output logic [pac_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: at_zero[0]
    output logic                           m_axis_tuser,
    input  logic                           i_cfg_we,
    input  logic [pac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pac_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import pac_pkg::*;

    t_cfg             r_cfg;
    t_q_stat          q_stat;
    logic             push;
    logic [SMP_W-1:0] push_mean;
    logic             pop;
    logic [SMP_W-1:0] pop_mean;
    logic [SMP_W-1:0] out_mean;
    logic [VAL_W-1:0] out_cal;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_tbl   <= '0;
            r_cfg.val_tbl   <= '0;
            r_cfg.pts_used  <= PTS_RESET;
            r_cfg.zs_enter  <= '0;
            r_cfg.zs_exit   <= '0;
            r_cfg.low_snap  <= '0;
            r_cfg.high_snap <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RAW_TABLE:   r_cfg.raw_tbl   <= i_cfg_wdata[RAW_TBL_W-1:0];
                CFG_VALUE_TABLE: r_cfg.val_tbl   <= i_cfg_wdata[VAL_TBL_W-1:0];
                CFG_POINTS_USED: r_cfg.pts_used  <= i_cfg_wdata[NPT_W-1:0];
                CFG_ZS_ENTER:    r_cfg.zs_enter  <= i_cfg_wdata[SNAP_W-1:0];
                CFG_ZS_EXIT:     r_cfg.zs_exit   <= i_cfg_wdata[SNAP_W-1:0];
                CFG_LOW_SNAP:    r_cfg.low_snap  <= i_cfg_wdata[SNAP_W-1:0];
                CFG_HIGH_SNAP:   r_cfg.high_snap <= i_cfg_wdata[SNAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pac_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata[SMP_W-1:0]),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_mean   (push_mean)
    );

    pac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_mean),
        .i_pop   (pop),
        .o_data  (pop_mean),
        .o_stat  (q_stat)
    );

    pac_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .i_q_data (pop_mean),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_mean   (out_mean),
        .o_cal    (out_cal),
        .o_zero   (m_axis_tuser)
    );

    assign m_axis_tdata = {{(M_TDATA_W - SMP_W - VAL_W){1'b0}}, out_cal, out_mean};

endmodule

FILE: rtl/pac_chk.sv
`include "assert_macros.svh"

module pac_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [pac_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);
    import pac_pkg::*;

    // A stalled result holds its payload
    `PAC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // The zero flag agrees with the calibrated value it travels with
    `PAC_ASSERT(a_zero_flag, m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[SMP_W+VAL_W-1:SMP_W] == '0)), "zero flag does not match value")

    // Padding above the result fields stays clear
    `PAC_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:SMP_W+VAL_W] == '0), "padding bits set")

    // Reset empties the output register
    `PAC_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind pot_average_calibrate_snap pac_chk u_chk (.*);

FILE: dv/pot_average_calibrate_snap_test.sv
module pot_average_calibrate_snap_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pac_pkg::*;

    // Cycles allowed for the back end to finish after the last reading
    localparam int BACKEND_CYCLES = 40;
    // Long receiver hold-off that lets the mean queue fill
    localparam int LONG_HOLD      = 2000;

    typedef struct packed {
        logic [SMP_W-1:0]        mean;
        logic signed [VAL_W-1:0] cal;
        logic                    zero;
    } pot_result_t;

    typedef struct {
        int          set_no;
        logic [9:0]  level;
        bit          typed;
        pot_result_t want;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: sample[9:0], zero padding above
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: mean_raw[9:0], calibrated_value[17:10], zero padding above
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // tuser: at_zero[0]
    logic                  m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Shadow of the block: configuration, running sum and last zero flag
    t_cfg        cfg_now;
    int          run_sum;
    int          run_count;
    bit          last_zero;

    pot_result_t pending_readings[$];
    int          bad_readings = 0;
    int          readings_due = 0;
    int          samples_sent = 0;

    // Stimulus controls shared with the receiver
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          stall_left = 0;

    // Typed expectation for the directed block under way
    bit          row_typed = 1'b0;
    pot_result_t row_want;

    dir_row_t    dir_rows [22];

    pot_average_calibrate_snap DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Mostly no gap, sometimes a few cycles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int points_in_use();
        int n;
        n = cfg_now.pts_used;
        if (n < 2) n = 2;
        if (n > CAL_POINTS) n = CAL_POINTS;
        return n;
    endfunction

    function automatic int raw_at(int i);
        return int'(cfg_now.raw_tbl[SMP_W*i +: SMP_W]);
    endfunction

    function automatic int value_at(int i);
        return int'($signed(cfg_now.val_tbl[VAL_W*i +: VAL_W]));
    endfunction

    // Map a mean through zero snap, end snaps and segment interpolation
    function automatic int calibrate_mean(int raw);
        int n, snap, lo_snap, hi_snap, d, lo, hi, i;
        n = points_in_use();
        snap = last_zero ? cfg_now.zs_exit : cfg_now.zs_enter;
        lo_snap = cfg_now.low_snap;
        hi_snap = cfg_now.high_snap;
        if (snap > 0) begin
            for (i = 0; i < n; i++) begin
                d = raw - raw_at(i);
                if (d < 0) d = -d;
                if (value_at(i) == 0 && d <= snap) return 0;
            end
        end
        if (raw <= raw_at(0) + lo_snap) return value_at(0);
        if (raw >= raw_at(n - 1) - hi_snap) return value_at(n - 1);
        for (i = 0; i + 1 < n; i++) begin
            lo = raw_at(i);
            hi = raw_at(i + 1);
            if (raw >= lo && raw <= hi) begin
                if (hi == lo) return value_at(i);
                return value_at(i) + (raw - lo) * (value_at(i + 1) - value_at(i)) / (hi - lo);
            end
        end
        return 0;
    endfunction

    // Accumulate one sample; a full block yields a reading
    function automatic bit absorb_sample(input logic [SMP_W-1:0] smp,
                                         output pot_result_t res);
        int avg, cal;
        run_sum = (run_sum + int'(smp)) & 16'hFFFF;
        run_count++;
        res = '0;
        if (run_count < SAMPLES) return 1'b0;
        avg = run_sum / SAMPLES;
        run_sum = 0;
        run_count = 0;
        cal = calibrate_mean(avg);
        last_zero = (cal == 0);
        res.mean = avg[SMP_W-1:0];
        res.cal = cal[VAL_W-1:0];
        res.zero = last_zero;
        return 1'b1;
    endfunction

    // Offer one sample, hold it until the transaction completes, then predict
    task automatic send_sample(input logic [SMP_W-1:0] smp);
        int gap;
        pot_result_t res;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata = S_TDATA_W'(SMP_W'($urandom));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = S_TDATA_W'(smp);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        samples_sent++;
        if (absorb_sample(smp, res)) begin
            pending_readings.push_back(row_typed ? row_want : res);
            readings_due++;
        end
    endtask

    // Stop offering, wait for every reading, then let the back end go quiet
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (BACKEND_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        case (idx)
            CFG_RAW_TABLE:   cfg_now.raw_tbl = val[RAW_TBL_W-1:0];
            CFG_VALUE_TABLE: cfg_now.val_tbl = val[VAL_TBL_W-1:0];
            CFG_POINTS_USED: cfg_now.pts_used = val[NPT_W-1:0];
            CFG_ZS_ENTER:    cfg_now.zs_enter = val[SNAP_W-1:0];
            CFG_ZS_EXIT:     cfg_now.zs_exit = val[SNAP_W-1:0];
            CFG_LOW_SNAP:    cfg_now.low_snap = val[SNAP_W-1:0];
            CFG_HIGH_SNAP:   cfg_now.high_snap = val[SNAP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(CFG_RAW_TABLE, CFG_DATA_W'(c.raw_tbl));
        write_reg(CFG_VALUE_TABLE, CFG_DATA_W'(c.val_tbl));
        write_reg(CFG_POINTS_USED, CFG_DATA_W'(c.pts_used));
        write_reg(CFG_ZS_ENTER, CFG_DATA_W'(c.zs_enter));
        write_reg(CFG_ZS_EXIT, CFG_DATA_W'(c.zs_exit));
        write_reg(CFG_LOW_SNAP, CFG_DATA_W'(c.low_snap));
        write_reg(CFG_HIGH_SNAP, CFG_DATA_W'(c.high_snap));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Hand-picked tables for the directed rows
    function automatic t_cfg preset_config(int set_no);
        t_cfg c;
        c = '0;
        c.pts_used = PTS_RESET;
        case (set_no)
            1: begin
                // ascending table with a zero point in the middle
                c.raw_tbl = {10'd1023, 10'd800, 10'd500, 10'd300, 10'd100, 10'd0};
                // 127, 100, 30, 0, -50, -128
                c.val_tbl = {8'h7F, 8'h64, 8'h1E, 8'h00, 8'hCE, 8'h80};
                c.pts_used = 3'd6;
                c.zs_enter = 10'd10;
                c.zs_exit = 10'd20;
                c.low_snap = 10'd5;
                c.high_snap = 10'd5;
            end
            2: begin
                // out of order, with two equal points; seven points asked for
                c.raw_tbl = {10'd1000, 10'd400, 10'd600, 10'd600, 10'd20, 10'd10};
                // -1, 77, 0, -100, 50, 100
                c.val_tbl = {8'hFF, 8'h4D, 8'h00, 8'h9C, 8'h32, 8'h64};
                c.pts_used = 3'd7;
                c.zs_exit = 10'd1023;
            end
            3, 4: begin
                // only two points count; the zero points above them must be ignored
                c.raw_tbl = {10'd5, 10'd5, 10'd5, 10'd5, 10'd1023, 10'd0};
                c.val_tbl = (set_no == 3) ? {32'h0, 8'h7F, 8'h80} : {32'h0, 8'h7F, 8'h00};
                c.pts_used = (set_no == 3) ? 3'd0 : 3'd1;
                c.zs_enter = 10'd1023;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [SNAP_W-1:0] snap_width();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            8:       return SNAP_W'($urandom_range(41, 300));
            9:       return '1;
            default: return SNAP_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        int p, k, step;
        bit messy;
        logic [VAL_W-1:0] v;
        c = '0;
        messy = ($urandom_range(0, 4) == 0);
        p = $urandom_range(0, 150);
        for (k = 0; k < CAL_POINTS; k++) begin
            if (messy) begin
                c.raw_tbl[SMP_W*k +: SMP_W] = SMP_W'($urandom_range(0, 1023));
            end else begin
                c.raw_tbl[SMP_W*k +: SMP_W] = SMP_W'(p);
                step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 170);
                p += step;
            end
        end
        // pin the ends of the table to the extremes now and then
        if ($urandom_range(0, 4) == 0) begin
            c.raw_tbl[SMP_W-1:0] = '0;
            c.raw_tbl[RAW_TBL_W-1 -: SMP_W] = '1;
        end
        for (k = 0; k < CAL_POINTS; k++) begin
            v = VAL_W'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
                0, 1:    v = '0;
                2:       v = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
                default: ;
            endcase
            c.val_tbl[VAL_W*k +: VAL_W] = v;
        end
        c.pts_used = ($urandom_range(0, 5) == 0) ? NPT_W'($urandom_range(0, 7))
                                                 : NPT_W'($urandom_range(2, 6));
        c.zs_enter = snap_width();
        c.zs_exit = snap_width();
        c.low_snap = snap_width();
        c.high_snap = snap_width();
        return c;
    endfunction

    // Aim a block at a random level, an extreme, or near a table point, often at the edge of a snap width
    function automatic int pick_level();
        int w, lvl;
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1023);
            1: return $urandom_range(0, 1) ? 1023 : 0;
            default: begin
                case ($urandom_range(0, 4))
                    0:       w = cfg_now.zs_enter;
                    1:       w = cfg_now.zs_exit;
                    2:       w = cfg_now.low_snap;
                    3:       w = cfg_now.high_snap;
                    default: w = $urandom_range(0, 3);
                endcase
                w += $urandom_range(0, 1);
                lvl = raw_at($urandom_range(0, points_in_use() - 1));
                lvl += $urandom_range(0, 1) ? w : -w;
                if (lvl < 0) lvl = 0;
                if (lvl > 1023) lvl = 1023;
                return lvl;
            end
        endcase
    endfunction

    // One block of samples, now and then scattered at random; otherwise paired offsets keep the mean on target
    task automatic send_block();
        int aim, amp, d, k, s;
        bit scatter;
        scatter = ($urandom_range(0, 5) == 0);
        aim = pick_level();
        amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 4);
        d = 0;
        for (k = 0; k < SAMPLES; k++) begin
            if (scatter) begin
                s = $urandom_range(0, 1023);
            end else begin
                if (k % 2 == 0) d = $urandom_range(0, amp);
                s = (k % 2 == 0) ? aim + d : aim - d;
                if (s < 0) s = 0;
                if (s > 1023) s = 1023;
            end
            send_sample(SMP_W'(s));
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(negedge i_clk) begin : drain_side
        if (hold_req) begin
            hold_req = 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!quiet) stall_left = idle_len();
        end
    end

    // Compare each reading with the oldest one predicted
    always @(posedge i_clk) begin : check_readings
        pot_result_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mean = m_axis_tdata[SMP_W-1:0];
            got.cal = m_axis_tdata[SMP_W +: VAL_W];
            got.zero = m_axis_tuser;
            if (pending_readings.size() == 0) begin
                $display("%0t: reading with none expected: mean=%0d cal=%0d zero=%0b",
                         $time, got.mean, got.cal, got.zero);
                bad_readings++;
            end else begin
                want = pending_readings.pop_front();
                if (got.mean !== want.mean || got.cal !== want.cal || got.zero !== want.zero)
                begin
                    $display("%0t: expected mean=%0d cal=%0d zero=%0b, got mean=%0d cal=%0d zero=%0b",
                             $time, want.mean, want.cal, want.zero,
                             got.mean, got.cal, got.zero);
                    bad_readings++;
                end
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("pot_average_calibrate_snap_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        int cur_set, k, blocks, phase_no;
        dir_rows = '{
            // reset tables: both points at 0 with value 0
            '{0, 10'd0,    1, '{10'd0,    0,    1'b1}},
            '{0, 10'd1023, 1, '{10'd1023, 0,    1'b1}},
            '{0, 10'd512,  1, '{10'd512,  0,    1'b1}},
            // end snaps, zero snap on entry and on exit
            '{1, 10'd0,    1, '{10'd0,    -128, 1'b0}},
            '{1, 10'd1023, 1, '{10'd1023, 127,  1'b0}},
            '{1, 10'd5,    1, '{10'd5,    -128, 1'b0}},
            '{1, 10'd1018, 1, '{10'd1018, 127,  1'b0}},
            '{1, 10'd310,  1, '{10'd310,  0,    1'b1}},
            '{1, 10'd320,  1, '{10'd320,  0,    1'b1}},
            '{1, 10'd321,  0, '{10'd0,    0,    1'b0}},
            '{1, 10'd289,  0, '{10'd0,    0,    1'b0}},
            '{1, 10'd50,   0, '{10'd0,    0,    1'b0}},
            // unordered table, falling slope, zero snap off on entry
            '{2, 10'd10,   1, '{10'd10,   100,  1'b0}},
            '{2, 10'd1000, 1, '{10'd1000, -1,   1'b0}},
            '{2, 10'd300,  0, '{10'd0,    0,    1'b0}},
            '{2, 10'd600,  0, '{10'd0,    0,    1'b0}},
            // point count below range
            '{3, 10'd512,  0, '{10'd0,    0,    1'b0}},
            '{3, 10'd1023, 1, '{10'd1023, 127,  1'b0}},
            '{4, 10'd1023, 1, '{10'd1023, 0,    1'b1}},
            '{4, 10'd1023, 1, '{10'd1023, 127,  1'b0}},
            '{4, 10'd1023, 1, '{10'd1023, 0,    1'b1}},
            '{4, 10'd0,    1, '{10'd0,    0,    1'b1}}
        };

        cfg_now = preset_config(0);
        run_sum = 0;
        run_count = 0;
        last_zero = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: one full block at a fixed level each
        cur_set = 0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].set_no != cur_set) begin
                settle();
                load_config(preset_config(dir_rows[k].set_no));
                cur_set = dir_rows[k].set_no;
            end
            row_typed = dir_rows[k].typed;
            row_want = dir_rows[k].want;
            repeat (SAMPLES) send_sample(dir_rows[k].level);
        end
        row_typed = 1'b0;

        // Random phases: new setting, a few blocks, sometimes a ragged tail
        phase_no = 0;
        while (phase_no == 0 || samples_sent < 1300) begin
            settle();
            load_config(random_config());
            quiet = (phase_no != 0) && ($urandom_range(0, 3) == 0);
            blocks = (phase_no == 0) ? 6 : $urandom_range(1, 4);
            for (k = 0; k < blocks; k++) begin
                if (phase_no == 0 && k == 0) begin
                    send_sample(SMP_W'($urandom_range(0, 1023)));
                    hold_req = 1'b1;
                end
                send_block();
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, SAMPLES - 1))
                    send_sample(SMP_W'($urandom_range(0, 1023)));
            end
            phase_no++;
        end

        settle();
        if (bad_readings == 0) begin
            $display("pot_average_calibrate_snap_test: done, clean");
        end else begin
            $display("pot_average_calibrate_snap_test: done, errors");
        end
        $finish;
    end

endmodule
